// File: sv/lst_pkg.sv
package lst_pkg;

  // Opcodes carried in the input tuser field
  typedef enum logic [1:0] {
    OP_ADVANCE   = 2'd0,
    OP_LCD_CTRL  = 2'd1,
    OP_LYC_WRITE = 2'd2,
    OP_STAT_WRITE = 2'd3
  } lst_op_e;

  // LCD mode codes as seen in the STAT read value
  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } lst_mode_e;

  localparam int unsigned DotW  = 10;
  localparam int unsigned LineW = 8;

  localparam logic [DotW-1:0] DotMax = '1;

  // Interrupt enable bit positions (STAT bits 3..6)
  localparam int unsigned IrqHblank = 0;
  localparam int unsigned IrqVblank = 1;
  localparam int unsigned IrqOam    = 2;
  localparam int unsigned IrqLyc    = 3;

  typedef struct packed {
    logic [DotW-1:0]  dot;
    lst_mode_e        mode;
    logic [LineW-1:0] line;
    logic             match;
    logic             lcd_on;
    logic [3:0]       irq_en;
    logic [LineW-1:0] lyc;
  } lst_state_t;

  typedef struct packed {
    logic       line_drawn;
    logic       frame_done;
    logic       status_request;
    logic       vblank_request;
    logic [7:0] status_byte;
    logic       match_flag;
    logic [7:0] line_number;
    logic [1:0] current_mode;
  } lst_result_t;

endpackage

// File: sv/lst_step.sv
module lst_step import lst_pkg::*; #(
  parameter int OAM_SCAN_DOTS = 80,
  parameter int DRAW_DOTS     = 172,
  parameter int HBLANK_DOTS   = 204,
  parameter int LINE_DOTS     = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int TOTAL_LINES   = 154
) (
  input  lst_state_t  state_i,
  input  lst_op_e     op_i,
  input  logic [7:0]  dots_i,
  input  logic [7:0]  val_i,
  output lst_state_t  state_o,
  output lst_result_t res_o
);

  logic [DotW:0]    sum;
  logic [DotW-1:0]  sat;
  logic [LineW:0]   next_line;
  logic             next_hit;
  logic             vb_req;
  logic             st_req;
  logic             frame;
  logic             drawn;
  lst_state_t       ns;

  assign sum       = {1'b0, state_i.dot} + {{(DotW + 1 - 8){1'b0}}, dots_i};
  assign sat       = sum[DotW] ? DotMax : sum[DotW-1:0];
  assign next_line = {1'b0, state_i.line} + {{LineW{1'b0}}, 1'b1};
  // unwrapped compare: stepping past 255 never matches
  assign next_hit  = (next_line == {1'b0, state_i.lyc});

  always_comb begin
    ns     = state_i;
    vb_req = 1'b0;
    st_req = 1'b0;
    frame  = 1'b0;
    drawn  = 1'b0;
    case (op_i)
      OP_ADVANCE: begin
        if (state_i.lcd_on) begin
          ns.dot = sat;
          case (state_i.mode)
            MODE_OAM: begin
              if (sat >= DotW'(OAM_SCAN_DOTS)) begin
                ns.dot  = sat - DotW'(OAM_SCAN_DOTS);
                ns.mode = MODE_DRAW;
              end
            end
            MODE_DRAW: begin
              if (sat >= DotW'(DRAW_DOTS)) begin
                ns.dot  = sat - DotW'(DRAW_DOTS);
                drawn   = 1'b1;
                ns.mode = MODE_HBLANK;
                st_req  = state_i.irq_en[IrqHblank];
              end
            end
            MODE_HBLANK: begin
              if (sat >= DotW'(HBLANK_DOTS)) begin
                ns.dot   = sat - DotW'(HBLANK_DOTS);
                ns.line  = next_line[LineW-1:0];
                ns.match = next_hit;
                if (next_hit && state_i.irq_en[IrqLyc]) st_req = 1'b1;
                if (next_line == (LineW+1)'(VISIBLE_LINES)) begin
                  ns.mode = MODE_VBLANK;
                  vb_req  = 1'b1;
                  frame   = 1'b1;
                  if (state_i.irq_en[IrqVblank]) st_req = 1'b1;
                end else begin
                  ns.mode = MODE_OAM;
                  if (state_i.irq_en[IrqOam]) st_req = 1'b1;
                end
              end
            end
            default: begin
              // VBlank: one whole line per step
              if (sat >= DotW'(LINE_DOTS)) begin
                ns.dot   = sat - DotW'(LINE_DOTS);
                ns.line  = next_line[LineW-1:0];
                ns.match = next_hit;
                if (next_hit && state_i.irq_en[IrqLyc]) st_req = 1'b1;
                if (next_line >= (LineW+1)'(TOTAL_LINES)) begin
                  // frame wrap: back to line 0 and compare again
                  ns.line  = '0;
                  ns.mode  = MODE_OAM;
                  ns.match = (state_i.lyc == '0);
                  if (state_i.irq_en[IrqOam]) st_req = 1'b1;
                  if ((state_i.lyc == '0) && state_i.irq_en[IrqLyc]) st_req = 1'b1;
                end
              end
            end
          endcase
        end
      end
      OP_LCD_CTRL: begin
        ns.lcd_on = val_i[7];
        if (state_i.lcd_on && !val_i[7]) begin
          ns.line = '0;
          ns.dot  = '0;
          ns.mode = MODE_HBLANK;
          st_req  = state_i.irq_en[IrqHblank];
        end
      end
      OP_LYC_WRITE: begin
        ns.lyc   = val_i;
        ns.match = (state_i.line == val_i);
        st_req   = (state_i.line == val_i) && state_i.irq_en[IrqLyc];
      end
      default: begin
        ns.irq_en = val_i[6:3];
      end
    endcase
  end

  assign state_o = ns;

  assign res_o.current_mode   = ns.mode;
  assign res_o.line_number    = ns.line;
  assign res_o.match_flag     = ns.match;
  assign res_o.status_byte    = {1'b1, ns.irq_en, ns.match, ns.mode};
  assign res_o.vblank_request = vb_req;
  assign res_o.status_request = st_req;
  assign res_o.frame_done     = frame;
  assign res_o.line_drawn     = drawn;

endmodule

// File: sv/lcd_scanline_mode_timer_core.sv
// Channel   Dir  Payload
// s_axis    in   tuser: opcode[1:0]; tdata: dot_cycles[7:0], write_value[15:8]
// m_axis    out  tdata: mode, line, match, STAT byte, irq strobes, frame/line strobes
//
// One result per input transfer, sustained at one item per clock while the output is not stalled.
// Each item passes two registers: an input register, then the timing step and the result register.
// Reset puts the timer in OAM scan on line 0 with the LCD off and all enables cleared.
// A stalled output holds its result; the input stage keeps taking transfers
// until it is full, so an item can sit in each of the two registers.
module lcd_scanline_mode_timer_core import lst_pkg::*; #(
  parameter int OAM_SCAN_DOTS = 80,
  parameter int DRAW_DOTS     = 172,
  parameter int HBLANK_DOTS   = 204,
  parameter int LINE_DOTS     = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int TOTAL_LINES   = 154
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] dot_cycles, [15:8] write_value
  input  logic [15:0] s_axis_tdata_i,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] current_mode, [9:2] line_number, [10] match_flag, [18:11] status_byte,
  // [19] vblank_request, [20] status_request, [21] frame_done, [22] line_drawn,
  // [23] zero
  output logic [23:0] m_axis_tdata_o
);

  // input register
  logic        in_v_q;
  lst_op_e     in_op_q;
  logic [7:0]  in_dots_q;
  logic [7:0]  in_val_q;

  // result register
  logic        out_v_q;
  lst_result_t out_q;

  // timer state
  lst_state_t  st_q;
  lst_state_t  st_d;
  lst_result_t res_d;

  logic        s1_adv;
  logic        in_xfer;

  assign s1_adv          = in_v_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_v_q || s1_adv;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_op_q   <= lst_op_e'(s_axis_tuser_i);
      in_dots_q <= s_axis_tdata_i[7:0];
      in_val_q  <= s_axis_tdata_i[15:8];
    end
  end

  lst_step #(
    .OAM_SCAN_DOTS (OAM_SCAN_DOTS),
    .DRAW_DOTS     (DRAW_DOTS),
    .HBLANK_DOTS   (HBLANK_DOTS),
    .LINE_DOTS     (LINE_DOTS),
    .VISIBLE_LINES (VISIBLE_LINES),
    .TOTAL_LINES   (TOTAL_LINES)
  ) u_step (
    .state_i (st_q),
    .op_i    (in_op_q),
    .dots_i  (in_dots_q),
    .val_i   (in_val_q),
    .state_o (st_d),
    .res_o   (res_d)
  );

  // state commits only when the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.dot    <= '0;
      st_q.mode   <= MODE_OAM;
      st_q.line   <= '0;
      st_q.match  <= 1'b0;
      st_q.lcd_on <= 1'b0;
      st_q.irq_en <= '0;
      st_q.lyc    <= '0;
    end else if (s1_adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready_i) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {1'b0, out_q};

  // dot counter stays cleared while the LCD is off
  a_dot_idle_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.lcd_on |-> (st_q.dot == '0))
    else $error("dot counter moved with LCD off");

  // register writes to LYC or STAT never move the mode
  a_write_keeps_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && ((in_op_q == OP_LYC_WRITE) || (in_op_q == OP_STAT_WRITE))
    |=> $stable(st_q.mode))
    else $error("mode changed on register write");

  // stalled output must not be overwritten by the input stage
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !m_axis_tready_i |-> !s1_adv)
    else $error("result register overrun");

  // frame strobe comes only with a VBlank entry and its request
  a_frame_vblank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.frame_done
    |-> out_q.vblank_request && (out_q.current_mode == MODE_VBLANK))
    else $error("frame strobe without VBlank entry");

endmodule

// File: tb/lcd_scanline_mode_timer_core_tb.sv
`timescale 1ns / 1ps

module lcd_scanline_mode_timer_core_tb;
  import lst_pkg::*;

  // Timing constants, passed to the DUT so both sides agree
  localparam int OAM_DOTS    = 80;
  localparam int DRAW_DOTS   = 172;
  localparam int HBLANK_DOTS = 204;
  localparam int LINE_DOTS   = 456;
  localparam int VIS_LINES   = 144;
  localparam int ALL_LINES   = 154;
  localparam int DOT_SAT     = 1023;

  localparam int RAND_ITEMS   = 1880;  // counted items in the random part
  localparam int DRAIN_CYCLES = 8;     // two-stage pipe, plus margin

  // One input transfer; want is used instead of the predictor when typed
  typedef struct {
    lst_op_e     op;
    logic [7:0]  dots;
    logic [7:0]  val;
    bit          has_want;
    lst_result_t want;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [15:0] s_tdata = '0;  // [7:0] dot_cycles, [15:8] write_value
  logic [1:0]  s_tuser = '0;  // [1:0] opcode
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_tdata;       // [1:0] mode .. [22] line_drawn, [23] zero

  // Predicted timer state
  int unsigned tm_dot;
  lst_mode_e   tm_mode;
  logic [7:0]  tm_line;
  logic        tm_match;
  logic        tm_lcd_on;
  logic [3:0]  tm_irq_en;
  logic [7:0]  tm_lyc;
  bit          irq_vblank;
  bit          irq_stat;

  lst_result_t timer_results_q[$];
  stim_t       dir_tbl[$];
  int          dir_idx = 0;
  int          rand_left = RAND_ITEMS;
  int          src_idle_pct = 23;
  int          snk_stall_pct = 79;
  int          errors = 0;

  stim_t       cur;
  bit          load_new;
  bit          have;
  lst_result_t pred;
  lst_result_t got;
  lst_result_t want;

  lcd_scanline_mode_timer_core #(
    .OAM_SCAN_DOTS(OAM_DOTS),
    .DRAW_DOTS(DRAW_DOTS),
    .HBLANK_DOTS(HBLANK_DOTS),
    .LINE_DOTS(LINE_DOTS),
    .VISIBLE_LINES(VIS_LINES),
    .TOTAL_LINES(ALL_LINES)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_tdata),
    .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Timer predictor
  // ---------------------------------------------------------------------------

  // Mode entry raises the matching STAT source; VBlank also raises its own irq
  function automatic void enter_mode(lst_mode_e m);
    tm_mode = m;
    case (m)
      MODE_HBLANK: if (tm_irq_en[IrqHblank]) irq_stat = 1'b1;
      MODE_VBLANK: begin
        irq_vblank = 1'b1;
        if (tm_irq_en[IrqVblank]) irq_stat = 1'b1;
      end
      MODE_OAM: if (tm_irq_en[IrqOam]) irq_stat = 1'b1;
      default: ;
    endcase
  endfunction

  // Compare uses the unwrapped line, so line 154 can still match LYC 154
  function automatic void lyc_compare(int unsigned ln);
    if (ln == tm_lyc) begin
      tm_match = 1'b1;
      if (tm_irq_en[IrqLyc]) irq_stat = 1'b1;
    end else begin
      tm_match = 1'b0;
    end
  endfunction

  function automatic lst_result_t timer_step(lst_op_e op, logic [7:0] dots,
                                             logic [7:0] val);
    int unsigned next_line;
    bit          frame;
    bit          drawn;
    lst_result_t res;
    irq_vblank = 1'b0;
    irq_stat   = 1'b0;
    frame      = 1'b0;
    drawn      = 1'b0;
    case (op)
      OP_ADVANCE: begin
        if (tm_lcd_on) begin
          // counter saturates before the threshold test; one transition max
          tm_dot = tm_dot + dots;
          if (tm_dot > DOT_SAT) tm_dot = DOT_SAT;
          case (tm_mode)
            MODE_OAM: begin
              if (tm_dot >= OAM_DOTS) begin
                tm_dot -= OAM_DOTS;
                enter_mode(MODE_DRAW);
              end
            end
            MODE_DRAW: begin
              if (tm_dot >= DRAW_DOTS) begin
                tm_dot -= DRAW_DOTS;
                drawn = 1'b1;
                enter_mode(MODE_HBLANK);
              end
            end
            MODE_HBLANK: begin
              if (tm_dot >= HBLANK_DOTS) begin
                tm_dot -= HBLANK_DOTS;
                next_line = tm_line + 1;
                tm_line = next_line[7:0];
                lyc_compare(next_line);
                if (next_line == VIS_LINES) begin
                  enter_mode(MODE_VBLANK);
                  frame = 1'b1;
                end else begin
                  enter_mode(MODE_OAM);
                end
              end
            end
            default: begin
              if (tm_dot >= LINE_DOTS) begin
                tm_dot -= LINE_DOTS;
                next_line = tm_line + 1;
                tm_line = next_line[7:0];
                lyc_compare(next_line);
                if (next_line >= ALL_LINES) begin
                  // end of frame: wrap, then compare again on line 0
                  tm_line = '0;
                  enter_mode(MODE_OAM);
                  lyc_compare(0);
                end
              end
            end
          endcase
        end
      end
      OP_LCD_CTRL: begin
        if (tm_lcd_on && !val[7]) begin
          tm_line = '0;
          tm_dot  = 0;
          enter_mode(MODE_HBLANK);
        end
        tm_lcd_on = val[7];
      end
      OP_LYC_WRITE: begin
        tm_lyc = val;
        lyc_compare(tm_line);
      end
      default: tm_irq_en = val[6:3];
    endcase
    res.current_mode   = tm_mode;
    res.line_number    = tm_line;
    res.match_flag     = tm_match;
    res.status_byte    = {1'b1, tm_irq_en, tm_match, tm_mode};
    res.vblank_request = irq_vblank;
    res.status_request = irq_stat;
    res.frame_done     = frame;
    res.line_drawn     = drawn;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic stim_t row(lst_op_e op, logic [7:0] dots, logic [7:0] val);
    stim_t s;
    s.op       = op;
    s.dots     = dots;
    s.val      = val;
    s.has_want = 1'b0;
    s.want     = '0;
    return s;
  endfunction

  // Row with a hand-written result; frame and line strobes are zero here
  function automatic stim_t row_want(lst_op_e op, logic [7:0] dots, logic [7:0] val,
                                     lst_mode_e mode, logic [7:0] line, logic match,
                                     logic [7:0] stat, logic vb, logic st);
    stim_t s;
    s = row(op, dots, val);
    s.has_want            = 1'b1;
    s.want.current_mode   = mode;
    s.want.line_number    = line;
    s.want.match_flag     = match;
    s.want.status_byte    = stat;
    s.want.vblank_request = vb;
    s.want.status_request = st;
    return s;
  endfunction

  // Mostly dot advances so the timer gets through whole frames; LCD-off
  // is rare since it throws the line back to 0. LYC is often aimed at
  // the line about to come or the frame edges.
  function automatic stim_t random_item();
    stim_t s;
    int    r;
    s = row(OP_ADVANCE, 8'($urandom), 8'($urandom));
    r = $urandom_range(99);
    if (r < 88) begin
      case ($urandom_range(19))
        0, 1, 2, 3:            s.dots = 8'($urandom_range(15));
        4, 5, 6, 7, 8, 9, 10:  s.dots = 8'($urandom_range(255, 200));
        default:               s.dots = 8'($urandom_range(255));
      endcase
    end else if (r < 89) begin
      s.op = OP_LCD_CTRL;
      if (tm_lcd_on) s.val[7] = ($urandom_range(9) != 0);
      else           s.val[7] = ($urandom_range(9) < 8);
    end else if (r < 95) begin
      s.op = OP_LYC_WRITE;
      case ($urandom_range(6))
        0:       s.val = tm_line;
        1:       s.val = tm_line + 8'd1;
        2:       s.val = 8'(VIS_LINES);
        3:       s.val = 8'(ALL_LINES - 1);
        4:       s.val = 8'(ALL_LINES);
        5:       s.val = 8'd0;
        default: s.val = 8'($urandom);
      endcase
    end else begin
      s.op = OP_STAT_WRITE;
    end
    // advances with the LCD off are ignored by the block, not counted
    if (s.op != OP_ADVANCE || tm_lcd_on) rand_left--;
    // idling phases: sender light / receiver heavy, then swapped, then none
    if (rand_left > (2 * RAND_ITEMS) / 3) begin
      src_idle_pct  = 23;
      snk_stall_pct = 79;
    end else if (rand_left > RAND_ITEMS / 3) begin
      src_idle_pct  = 79;
      snk_stall_pct = 23;
    end else begin
      src_idle_pct  = 0;
      snk_stall_pct = 0;
    end
    return s;
  endfunction

  // Source side: on a transfer the item is run through the predictor and
  // its result queued, then the next item (or an idle cycle) is driven.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      load_new = !s_valid;
      if (s_valid && s_ready) begin
        pred = timer_step(cur.op, cur.dots, cur.val);
        timer_results_q.push_back(cur.has_want ? cur.want : pred);
        load_new = 1'b1;
      end
      if (load_new) begin
        have = 1'b0;
        if ($urandom_range(99) >= src_idle_pct) begin
          if (dir_idx < dir_tbl.size()) begin
            cur = dir_tbl[dir_idx];
            dir_idx++;
            have = 1'b1;
          end else if (rand_left > 0) begin
            cur  = random_item();
            have = 1'b1;
          end
        end
        s_valid <= have;
        if (have) begin
          s_tdata <= {cur.val, cur.dots};
          s_tuser <= cur.op;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_v,
               act_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        got = lst_result_t'(m_tdata[22:0]);
        if (timer_results_q.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: expected nothing, actual 0x%06h",
                   $time, m_tdata);
        end else begin
          want = timer_results_q.pop_front();
          check_field("current_mode", want.current_mode, got.current_mode);
          check_field("line_number", want.line_number, got.line_number);
          check_field("match_flag", want.match_flag, got.match_flag);
          check_field("status_byte", want.status_byte, got.status_byte);
          check_field("vblank_request", want.vblank_request, got.vblank_request);
          check_field("status_request", want.status_request, got.status_request);
          check_field("frame_done", want.frame_done, got.frame_done);
          check_field("line_drawn", want.line_drawn, got.line_drawn);
          check_field("tdata pad", 0, m_tdata[23]);
        end
      end
      m_ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    tm_dot    = 0;
    tm_mode   = MODE_OAM;
    tm_line   = '0;
    tm_match  = 1'b0;
    tm_lcd_on = 1'b0;
    tm_irq_en = '0;
    tm_lyc    = '0;

    // After reset: LCD off, OAM scan, line 0, no match yet
    dir_tbl.push_back(row_want(OP_ADVANCE, 8'hFF, 8'h00, MODE_OAM, 8'd0, 1'b0,
                               8'h82, 1'b0, 1'b0));
    // All STAT enables on; a STAT write raises nothing by itself
    dir_tbl.push_back(row_want(OP_STAT_WRITE, 8'h00, 8'hFF, MODE_OAM, 8'd0, 1'b0,
                               8'hFA, 1'b0, 1'b0));
    // LYC write matches at once, even with the LCD off
    dir_tbl.push_back(row_want(OP_LYC_WRITE, 8'hFF, 8'h00, MODE_OAM, 8'd0, 1'b1,
                               8'hFE, 1'b0, 1'b1));
    dir_tbl.push_back(row_want(OP_LCD_CTRL, 8'h00, 8'h80, MODE_OAM, 8'd0, 1'b1,
                               8'hFE, 1'b0, 1'b0));
    // Thresholds hit exactly: OAM -> draw -> HBlank -> next line
    dir_tbl.push_back(row(OP_ADVANCE, 8'd0, 8'h00));
    dir_tbl.push_back(row(OP_ADVANCE, 8'd79, 8'h00));
    dir_tbl.push_back(row(OP_ADVANCE, 8'd1, 8'h00));
    dir_tbl.push_back(row(OP_ADVANCE, 8'd171, 8'hFF));
    dir_tbl.push_back(row(OP_ADVANCE, 8'd1, 8'h00));
    dir_tbl.push_back(row(OP_ADVANCE, 8'd203, 8'h00));
    dir_tbl.push_back(row(OP_ADVANCE, 8'd1, 8'h00));
    dir_tbl.push_back(row(OP_LYC_WRITE, 8'h00, 8'h01));
    dir_tbl.push_back(row(OP_STAT_WRITE, 8'hFF, 8'h00));
    // Full-size advances pile up dots; the counter grows but stays short of saturation
    repeat (7) dir_tbl.push_back(row(OP_ADVANCE, 8'hFF, 8'h00));
    // Switch off mid-line, advance while off, switch back on
    dir_tbl.push_back(row(OP_LCD_CTRL, 8'hFF, 8'h00));
    dir_tbl.push_back(row(OP_ADVANCE, 8'hFF, 8'hFF));
    dir_tbl.push_back(row(OP_LCD_CTRL, 8'h00, 8'hFF));
    dir_tbl.push_back(row_want(OP_LYC_WRITE, 8'h00, 8'hFF, MODE_HBLANK, 8'd0, 1'b0,
                               8'h80, 1'b0, 1'b0));
    dir_tbl.push_back(row(OP_STAT_WRITE, 8'h00, 8'h87));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (dir_idx < dir_tbl.size() || rand_left > 0 || s_valid ||
           timer_results_q.size() != 0);
    // catch any stray result after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("lcd_scanline_mode_timer_core test passed");
    end else begin
      $display("lcd_scanline_mode_timer_core test failed");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run
  initial begin
    #1000000;
    $display("lcd_scanline_mode_timer_core test failed");
    $finish;
  end

endmodule
